/* rtl/core/oit_pkg.sv */
// Shared types, codes and sizes of the off-CPU interval tracker.
package oit_pkg;

    localparam int TABLE_ENTRIES = 64;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);

    localparam logic [1:0] REQ_SWITCH_OUT = 2'd0;
    localparam logic [1:0] REQ_SWITCH_IN  = 2'd1;
    localparam logic [1:0] REQ_WAKEUP     = 2'd2;
    localparam logic [1:0] REQ_EXIT       = 2'd3;

    localparam logic [3:0] ST_IGNORED     = 4'd0;
    localparam logic [3:0] ST_TRACKED     = 4'd1;
    localparam logic [3:0] ST_BLOCKED_EMIT = 4'd2;
    localparam logic [3:0] ST_RUNQ_EMIT   = 4'd3;
    localparam logic [3:0] ST_BELOW_MIN   = 4'd4;
    localparam logic [3:0] ST_ABOVE_MAX   = 4'd5;
    localparam logic [3:0] ST_CTX_ERROR   = 4'd6;
    localparam logic [3:0] ST_TABLE_FULL  = 4'd7;
    localparam logic [3:0] ST_CLEANED_UP  = 4'd8;
    localparam logic [3:0] ST_SUPPRESSED  = 4'd9;

    localparam logic [1:0] CFG_METRIC_MODE  = 2'd0;
    localparam logic [1:0] CFG_MIN_DURATION = 2'd1;
    localparam logic [1:0] CFG_MAX_DURATION = 2'd2;

    localparam logic [1:0] MM_BOTH    = 2'd0;
    localparam logic [1:0] MM_BLOCKED = 2'd1;

    localparam logic KIND_BLOCKED = 1'b0;
    localparam logic KIND_RUNQ    = 1'b1;

    localparam logic [1:0] FLG_PREEMPTED = 2'b01;
    localparam logic [1:0] FLG_YIELDED   = 2'b10;

    localparam logic [63:0] MIN_DURATION_RST = 64'd1000000;
    localparam logic [63:0] MAX_DURATION_RST = 64'd0;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [63:0] task_key;
        logic [63:0] event_time;
        logic        preempted;
        logic        still_running;
        logic        task_eligible;
        logic        context_ok;
        logic [31:0] context_tag;
        logic [7:0]  cpu_id;
    } t_req;

    typedef struct packed {
        logic [3:0]  status;
        logic        event_valid;
        logic        event_kind;
        logic [2:0]  event_flags;
        logic [63:0] interval_start;
        logic [63:0] interval_end;
        logic [63:0] interval_length;
        logic [31:0] out_context;
        logic [7:0]  out_cpu;
    } t_res;

    typedef struct packed {
        logic        phase;
        logic [1:0]  flags;
        logic [63:0] start_time;
        logic [31:0] ctx_tag;
    } t_entry;

    typedef struct packed {
        logic [1:0]  metric_mode;
        logic [63:0] min_duration;
        logic [63:0] max_duration;
    } t_cfg;

    typedef struct packed {
        logic             hit;
        logic [IDX_W-1:0] hit_idx;
        logic             free;
        logic [IDX_W-1:0] free_idx;
    } t_lookup;

    typedef struct packed {
        logic             set;
        logic             clr;
        logic [IDX_W-1:0] idx;
        logic [63:0]      key;
    } t_tag_wr;

endpackage

/* rtl/core/oit_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module oit_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/oit_tag_store.sv */
// Task key store with valid bits, parallel key match and lowest free slot search.
module oit_tag_store (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [63:0]      i_key,
    input  oit_pkg::t_tag_wr i_wr,
    output oit_pkg::t_lookup o_lookup
);
    import oit_pkg::*;

    logic [TABLE_ENTRIES-1:0] r_valid;
    logic [63:0]              r_key [TABLE_ENTRIES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr.set) begin
            r_valid[i_wr.idx] <= 1'b1;
        end else if (i_wr.clr) begin
            r_valid[i_wr.idx] <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.set) begin
            r_key[i_wr.idx] <= i_wr.key;
        end
    end

    always_comb begin
        o_lookup = '0;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (r_valid[i] && (r_key[i] == i_key)) begin
                o_lookup.hit     = 1'b1;
                o_lookup.hit_idx = o_lookup.hit_idx | IDX_W'(i);
            end
        end
        for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                o_lookup.free     = 1'b1;
                o_lookup.free_idx = IDX_W'(i);
            end
        end
    end

endmodule

/* rtl/core/oit_close.sv */
// Interval close: kind filter, duration limits and result fields.
module oit_close (
    input  oit_pkg::t_entry i_entry,
    input  oit_pkg::t_req   i_req,
    input  oit_pkg::t_cfg   i_cfg,
    input  logic            i_kind,
    input  logic            i_missed,
    output oit_pkg::t_res   o_res
);
    import oit_pkg::*;

    logic        kind_en;
    logic [63:0] len;

    always_comb begin
        case (i_cfg.metric_mode)
            MM_BOTH:    kind_en = 1'b1;
            MM_BLOCKED: kind_en = (i_kind == KIND_BLOCKED);
            default:    kind_en = (i_kind == KIND_RUNQ);
        endcase
    end

    assign len = i_req.event_time - i_entry.start_time;

    always_comb begin
        o_res = '0;
        if (!kind_en || (i_req.event_time <= i_entry.start_time)) begin
            o_res.status = ST_SUPPRESSED;
        end else if (len < i_cfg.min_duration) begin
            o_res.status = ST_BELOW_MIN;
        end else if ((i_cfg.max_duration != '0) && (len > i_cfg.max_duration)) begin
            o_res.status = ST_ABOVE_MAX;
        end else begin
            o_res.status          = (i_kind == KIND_BLOCKED) ? ST_BLOCKED_EMIT : ST_RUNQ_EMIT;
            o_res.event_valid     = 1'b1;
            o_res.event_kind      = i_kind;
            o_res.event_flags     = {i_missed, i_entry.flags};
            o_res.interval_start  = i_entry.start_time;
            o_res.interval_end    = i_req.event_time;
            o_res.interval_length = len;
            o_res.out_context     = i_entry.ctx_tag;
            o_res.out_cpu         = i_req.cpu_id;
        end
    end

endmodule

/* rtl/core/offcpu_interval_tracker.sv */
// Top level of the off-CPU interval tracker: command port, table update and result register.
//
//   channel   direction  handshake                 payload
//   command   in         start high, busy low      i_req  (t_req)
//   result    out        o_res_strobe, one cycle   o_res  (t_res)
//   config    in         i_cfg_we                  i_cfg_idx, i_cfg_data
//
// A command is taken while busy is low: the accepting edge registers the command together
// with the key match and reads the entry RAM; the next edge updates the table and loads the
// result register. Result and strobe are held for the cycle after that.
// Reset clears the valid bits and loads the configuration defaults; no clearing pass is needed.
// The receiver cannot stall; busy is high only during the update cycle.
module offcpu_interval_tracker (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  oit_pkg::t_req i_req,
    output logic          o_res_strobe,
    output oit_pkg::t_res o_res,
    input  logic          i_cfg_we,
    input  logic [1:0]    i_cfg_idx,
    input  logic [63:0]   i_cfg_data
);
    import oit_pkg::*;

    logic    r_busy;
    logic    r_strobe;
    t_req    r_req;
    t_lookup r_lk;
    t_res    r_res;
    t_cfg    r_cfg;

    t_lookup  lk;
    t_tag_wr  tag_wr;
    t_entry   rd_entry;
    t_entry   wr_entry;
    logic     ram_we;
    t_res     close_res;
    t_res     n_res;
    logic     accept;
    logic     key_nz;
    logic     missed;

    assign accept = start && !r_busy;
    assign busy   = r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.metric_mode  <= MM_BOTH;
            r_cfg.min_duration <= MIN_DURATION_RST;
            r_cfg.max_duration <= MAX_DURATION_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_METRIC_MODE:  r_cfg.metric_mode  <= i_cfg_data[1:0];
                CFG_MIN_DURATION: r_cfg.min_duration <= i_cfg_data;
                CFG_MAX_DURATION: r_cfg.max_duration <= i_cfg_data;
                default:          ;
            endcase
        end
    end

    oit_tag_store u_tags (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_key    (i_req.task_key),
        .i_wr     (tag_wr),
        .o_lookup (lk)
    );

    oit_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (TABLE_ENTRIES)
    ) u_entries (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (tag_wr.idx),
        .i_wdata (wr_entry),
        .i_raddr (lk.hit_idx),
        .o_rdata (rd_entry)
    );

    // busy marks the update cycle and drives the strobe register; the command and its match are held in the block below
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_busy   <= accept;
            r_strobe <= r_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req <= i_req;
            r_lk  <= lk;
        end
        if (r_busy) begin
            r_res <= n_res;
        end
    end

    assign key_nz = (r_req.task_key != '0);
    assign missed = (r_req.req_type == REQ_SWITCH_IN) && !rd_entry.phase;

    oit_close u_close (
        .i_entry  (rd_entry),
        .i_req    (r_req),
        .i_cfg    (r_cfg),
        .i_kind   (rd_entry.phase),
        .i_missed (missed),
        .o_res    (close_res)
    );

    always_comb begin
        n_res       = '0;
        tag_wr      = '0;
        tag_wr.idx  = r_lk.hit_idx;
        tag_wr.key  = r_req.task_key;
        ram_we      = 1'b0;
        wr_entry    = rd_entry;
        unique case (r_req.req_type)
            REQ_SWITCH_OUT: begin
                if (key_nz && r_req.task_eligible) begin
                    if (!r_req.context_ok) begin
                        n_res.status = ST_CTX_ERROR;
                    end else if (r_lk.hit || r_lk.free) begin
                        tag_wr.set          = r_busy;
                        tag_wr.idx          = r_lk.hit ? r_lk.hit_idx : r_lk.free_idx;
                        ram_we              = r_busy;
                        wr_entry.start_time = r_req.event_time;
                        wr_entry.ctx_tag    = r_req.context_tag;
                        if (r_req.preempted || r_req.still_running) begin
                            wr_entry.phase = 1'b1;
                            wr_entry.flags = r_req.preempted ? FLG_PREEMPTED : FLG_YIELDED;
                        end else begin
                            wr_entry.phase = 1'b0;
                            wr_entry.flags = '0;
                        end
                        n_res.status = ST_TRACKED;
                    end else begin
                        n_res.status = ST_TABLE_FULL;
                    end
                end
            end
            REQ_SWITCH_IN: begin
                if (key_nz && r_req.task_eligible && r_lk.hit) begin
                    n_res      = close_res;
                    tag_wr.clr = r_busy;
                end
            end
            REQ_WAKEUP: begin
                if (key_nz && r_lk.hit && !rd_entry.phase) begin
                    n_res               = close_res;
                    ram_we              = r_busy;
                    wr_entry.phase      = 1'b1;
                    wr_entry.start_time = r_req.event_time;
                end
            end
            REQ_EXIT: begin
                if (key_nz && r_lk.hit) begin
                    tag_wr.clr   = r_busy;
                    n_res.status = ST_CLEANED_UP;
                end
            end
            default: ;
        endcase
    end

    assign o_res_strobe = r_strobe;
    assign o_res        = r_res;

endmodule

/* tb/sv/offcpu_interval_tracker_tb.sv */
// Testbench of the off-CPU interval tracker: directed and random scheduler events checked against an interval ledger.
module offcpu_interval_tracker_tb;
    import oit_pkg::*;

    class interval_ledger;
        logic [1:0]  mode;
        logic [63:0] min_ns;
        logic [63:0] max_ns;
        bit          slot_live [TABLE_ENTRIES];
        logic [63:0] slot_key [TABLE_ENTRIES];
        t_entry      slot [TABLE_ENTRIES];
        t_res        pending_results [$];
        int          mismatches;

        localparam logic [2:0] FLG_MISSED_WAKEUP = 3'b100;

        function new();
            mode       = MM_BOTH;
            min_ns     = MIN_DURATION_RST;
            max_ns     = MAX_DURATION_RST;
            mismatches = 0;
            foreach (slot_live[i]) begin
                slot_live[i] = 1'b0;
            end
        endfunction

        function void write_cfg(logic [1:0] idx, logic [63:0] data);
            case (idx)
                CFG_METRIC_MODE:  mode   = data[1:0];
                CFG_MIN_DURATION: min_ns = data;
                CFG_MAX_DURATION: max_ns = data;
                default: ;
            endcase
        endfunction

        function int find_key(logic [63:0] key);
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                if (slot_live[i] && slot_key[i] == key) return i;
            end
            return -1;
        endfunction

        function t_res close_phase(int s, logic [63:0] fin, logic kind, logic [2:0] extra,
                                   logic [7:0] cpu);
            t_res        res;
            logic [63:0] span;
            logic        enabled;
            res  = '0;
            span = fin - slot[s].start_time;
            if (mode == MM_BOTH) enabled = 1'b1;
            else if (mode == MM_BLOCKED) enabled = (kind == KIND_BLOCKED);
            else enabled = (kind == KIND_RUNQ);
            if (!enabled || fin <= slot[s].start_time) begin
                res.status = ST_SUPPRESSED;
            end else if (span < min_ns) begin
                res.status = ST_BELOW_MIN;
            end else if (max_ns != 64'd0 && span > max_ns) begin
                res.status = ST_ABOVE_MAX;
            end else begin
                res.status          = (kind == KIND_BLOCKED) ? ST_BLOCKED_EMIT : ST_RUNQ_EMIT;
                res.event_valid     = 1'b1;
                res.event_kind      = kind;
                res.event_flags     = {1'b0, slot[s].flags} | extra;
                res.interval_start  = slot[s].start_time;
                res.interval_end    = fin;
                res.interval_length = span;
                res.out_context     = slot[s].ctx_tag;
                res.out_cpu         = cpu;
            end
            return res;
        endfunction

        function void note_command(t_req cmd);
            t_res res;
            int   s;
            res = '0;
            res.status = ST_IGNORED;
            if (cmd.task_key != 64'd0) begin
                case (cmd.req_type)
                    REQ_SWITCH_OUT: begin
                        if (!cmd.task_eligible) begin
                            res.status = ST_IGNORED;
                        end else if (!cmd.context_ok) begin
                            res.status = ST_CTX_ERROR;
                        end else begin
                            s = find_key(cmd.task_key);
                            for (int i = 0; i < TABLE_ENTRIES && s < 0; i++) begin
                                if (!slot_live[i]) s = i;
                            end
                            if (s < 0) begin
                                res.status = ST_TABLE_FULL;
                            end else begin
                                slot_live[s]          = 1'b1;
                                slot_key[s]           = cmd.task_key;
                                slot[s].start_time    = cmd.event_time;
                                slot[s].ctx_tag       = cmd.context_tag;
                                if (cmd.preempted || cmd.still_running) begin
                                    slot[s].phase = 1'b1;
                                    slot[s].flags = cmd.preempted ? FLG_PREEMPTED : FLG_YIELDED;
                                end else begin
                                    slot[s].phase = 1'b0;
                                    slot[s].flags = 2'b00;
                                end
                                res.status = ST_TRACKED;
                            end
                        end
                    end
                    REQ_SWITCH_IN: begin
                        s = cmd.task_eligible ? find_key(cmd.task_key) : -1;
                        if (s >= 0) begin
                            if (slot[s].phase)
                                res = close_phase(s, cmd.event_time, KIND_RUNQ, 3'b000,
                                                  cmd.cpu_id);
                            else
                                res = close_phase(s, cmd.event_time, KIND_BLOCKED,
                                                  FLG_MISSED_WAKEUP, cmd.cpu_id);
                            slot_live[s] = 1'b0;
                        end
                    end
                    REQ_WAKEUP: begin
                        s = find_key(cmd.task_key);
                        if (s >= 0 && !slot[s].phase) begin
                            res = close_phase(s, cmd.event_time, KIND_BLOCKED, 3'b000,
                                              cmd.cpu_id);
                            slot[s].phase      = 1'b1;
                            slot[s].start_time = cmd.event_time;
                        end
                    end
                    default: begin
                        s = find_key(cmd.task_key);
                        if (s >= 0) begin
                            slot_live[s] = 1'b0;
                            res.status   = ST_CLEANED_UP;
                        end
                    end
                endcase
            end
            pending_results.push_back(res);
        endfunction

        function void compare_field(string name, logic [63:0] want, logic [63:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
                mismatches++;
            end
        endfunction

        function void check_result(t_res got);
            t_res want;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected transaction, expected none, actual %h", $time, got);
                mismatches++;
                return;
            end
            want = pending_results.pop_front();
            compare_field("status", want.status, got.status);
            compare_field("event_valid", want.event_valid, got.event_valid);
            compare_field("event_kind", want.event_kind, got.event_kind);
            compare_field("event_flags", want.event_flags, got.event_flags);
            compare_field("interval_start", want.interval_start, got.interval_start);
            compare_field("interval_end", want.interval_end, got.interval_end);
            compare_field("interval_length", want.interval_length, got.interval_length);
            compare_field("out_context", want.out_context, got.out_context);
            compare_field("out_cpu", want.out_cpu, got.out_cpu);
        endfunction
    endclass

    localparam int         STALL_LIMIT = 2000;
    localparam int         KEY_POOL    = 96;
    localparam logic [1:0] MM_RUNQ     = 2'd2;
    localparam logic [1:0] MM_RUNQ_ALT = 2'd3;

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        start        = 1'b0;
    t_req        i_req        = '0;
    logic        i_cfg_we     = 1'b0;
    logic [1:0]  i_cfg_idx    = CFG_METRIC_MODE;
    logic [63:0] i_cfg_data   = '0;
    logic        busy;
    logic        o_res_strobe;
    t_res        o_res;

    interval_ledger ledger;
    logic [63:0]    task_keys [KEY_POOL];
    logic [63:0]    sched_ns = '0;
    int             quiet_cycles = 0;

    offcpu_interval_tracker dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_req        (i_req),
        .o_res_strobe (o_res_strobe),
        .o_res        (o_res),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_res_strobe) ledger.check_result(o_res);
            if (start && !busy) ledger.note_command(i_req);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_res_strobe) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("offcpu_interval_tracker test failed");
            $finish;
        end
    end

    function automatic t_req mk(logic [1:0] req, logic [63:0] key, logic [63:0] at,
                                logic pre, logic run, logic elig, logic ok,
                                logic [31:0] tag, logic [7:0] cpu);
        t_req cmd;
        cmd.req_type      = req;
        cmd.task_key      = key;
        cmd.event_time    = at;
        cmd.preempted     = pre;
        cmd.still_running = run;
        cmd.task_eligible = elig;
        cmd.context_ok    = ok;
        cmd.context_tag   = tag;
        cmd.cpu_id        = cpu;
        return cmd;
    endfunction

    task automatic send_cmd(input t_req cmd);
        start <= 1'b1;
        i_req <= cmd;
        do @(posedge i_clk); while (busy);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (ledger.pending_results.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [63:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        ledger.write_cfg(idx, data);
    endtask

    task automatic set_config(input logic [1:0] mode, input logic [63:0] min_ns,
                              input logic [63:0] max_ns);
        wait_drained();
        write_reg(CFG_METRIC_MODE, {62'($urandom), mode});
        write_reg(CFG_MIN_DURATION, min_ns);
        write_reg(CFG_MAX_DURATION, max_ns);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic run_directed();
        logic [63:0] k1;
        logic [63:0] k2;
        logic [63:0] k3;
        logic [63:0] k4;
        k1 = 64'h0123_4567_89ab_cdef;
        k2 = 64'hfedc_ba98_7654_3210;
        k3 = 64'h8000_0000_0000_0001;
        k4 = 64'h5a5a_a5a5_0f0f_f0f0;
        send_cmd(mk(REQ_SWITCH_OUT, 64'd0, 64'd5000, 1'b0, 1'b0, 1'b1, 1'b1, '1, 8'd3));
        send_cmd(mk(REQ_SWITCH_OUT, k1, 64'd100, 1'b0, 1'b0, 1'b0, 1'b1, 32'd1, 8'd1));
        send_cmd(mk(REQ_SWITCH_OUT, k1, 64'd100, 1'b0, 1'b0, 1'b1, 1'b0, 32'd1, 8'd1));
        send_cmd(mk(REQ_SWITCH_OUT, k1, 64'd1000, 1'b0, 1'b0, 1'b1, 1'b1, '0, 8'd0));
        // overwrite in place: preempted wins over still running
        send_cmd(mk(REQ_SWITCH_OUT, k1, 64'd2000, 1'b1, 1'b1, 1'b1, 1'b1, '1, 8'd0));
        send_cmd(mk(REQ_WAKEUP, k1, 64'd3000, 1'b0, 1'b0, 1'b1, 1'b1, '0, 8'd2));
        send_cmd(mk(REQ_SWITCH_IN, k1, 64'd9000000, 1'b0, 1'b0, 1'b0, 1'b1, '0, 8'd2));
        send_cmd(mk(REQ_SWITCH_IN, k1, 64'd7002000, 1'b0, 1'b0, 1'b1, 1'b1, '0, '1));
        send_cmd(mk(REQ_SWITCH_IN, k1, 64'd8000000, 1'b0, 1'b0, 1'b1, 1'b1, '0, 8'd4));
        send_cmd(mk(REQ_WAKEUP, k2, 64'd10, 1'b0, 1'b0, 1'b1, 1'b1, '0, 8'd5));
        send_cmd(mk(REQ_EXIT, k2, 64'd10, 1'b0, 1'b0, 1'b1, 1'b1, '0, 8'd5));
        send_cmd(mk(REQ_SWITCH_OUT, k2, 64'd10, 1'b0, 1'b1, 1'b1, 1'b1, 32'hdead_beef, 8'd6));
        send_cmd(mk(REQ_SWITCH_IN, k2, 64'd510, 1'b0, 1'b0, 1'b1, 1'b1, '0, 8'd6));
        send_cmd(mk(REQ_SWITCH_OUT, k3, '1, 1'b0, 1'b0, 1'b1, 1'b1, 32'h1234_5678, 8'd7));
        // wakeup and switch in that do not end after the start
        send_cmd(mk(REQ_WAKEUP, k3, 64'd5, 1'b0, 1'b0, 1'b1, 1'b1, '0, 8'd7));
        send_cmd(mk(REQ_SWITCH_IN, k3, 64'd5, 1'b0, 1'b0, 1'b1, 1'b1, '0, 8'd7));
        send_cmd(mk(REQ_SWITCH_OUT, '1, 64'd0, 1'b0, 1'b0, 1'b1, 1'b1, 32'h8765_4321, 8'd8));
        send_cmd(mk(REQ_WAKEUP, '1, 64'd3000000, 1'b0, 1'b0, 1'b0, 1'b0, '0, 8'd9));
        send_cmd(mk(REQ_SWITCH_IN, '1, 64'd5000000, 1'b0, 1'b0, 1'b1, 1'b1, '0, 8'd10));
        send_cmd(mk(REQ_SWITCH_OUT, k4, 64'd100, 1'b0, 1'b0, 1'b1, 1'b1, 32'h0bad_f00d, 8'd11));
        send_cmd(mk(REQ_SWITCH_IN, k4, 64'd2000100, 1'b0, 1'b0, 1'b1, 1'b1, '0, 8'd12));
        send_cmd(mk(REQ_SWITCH_OUT, k4, 64'd300, 1'b1, 1'b0, 1'b1, 1'b1, 32'd9, 8'd13));
        send_cmd(mk(REQ_EXIT, k4, 64'd400, 1'b0, 1'b0, 1'b0, 1'b0, '0, 8'd13));
        send_cmd(mk(REQ_EXIT, k4, 64'd500, 1'b0, 1'b0, 1'b1, 1'b1, '0, 8'd13));
        set_config(MM_BOTH, MIN_DURATION_RST, 64'd1500000);
        send_cmd(mk(REQ_SWITCH_OUT, k1, 64'd0, 1'b0, 1'b0, 1'b1, 1'b1, 32'd77, 8'd14));
        send_cmd(mk(REQ_SWITCH_IN, k1, 64'd5000000, 1'b0, 1'b0, 1'b1, 1'b1, '0, 8'd15));
    endtask

    task automatic run_phase(input logic [1:0] mode, input logic [63:0] min_ns,
                             input logic [63:0] max_ns, input int idle_pct,
                             input int pool_n, input int out_pct, input int n_items);
        t_req cmd;
        int   roll;
        set_config(mode, min_ns, max_ns);
        for (int n = 0; n < n_items; n++) begin
            if ($urandom_range(99) < idle_pct) begin
                start <= 1'b0;
                do @(negedge i_clk); while ($urandom_range(99) < idle_pct);
            end
            cmd.preempted     = $urandom_range(1);
            cmd.still_running = $urandom_range(1);
            cmd.task_eligible = $urandom_range(99) < 92;
            cmd.context_ok    = $urandom_range(99) < 94;
            cmd.context_tag   = $urandom;
            cmd.cpu_id        = $urandom_range(255);
            if ($urandom_range(99) < 8) begin
                cmd.req_type   = 2'($urandom_range(3));
                cmd.task_key   = {$urandom, $urandom};
                cmd.event_time = {$urandom, $urandom};
            end else begin
                if ($urandom_range(99) < out_pct) begin
                    cmd.req_type = REQ_SWITCH_OUT;
                end else begin
                    roll = $urandom_range(9);
                    cmd.req_type = (roll < 4) ? REQ_SWITCH_IN :
                                   (roll < 8) ? REQ_WAKEUP : REQ_EXIT;
                end
                cmd.task_key = ($urandom_range(49) == 0) ? 64'd0 :
                               task_keys[$urandom_range(pool_n - 1)];
                roll = $urandom_range(19);
                case (roll)
                    0:                    ;
                    1, 2, 3, 4, 5, 6, 7:  sched_ns = sched_ns + $urandom_range(400000);
                    8, 9, 10, 11, 12, 13, 14:
                                          sched_ns = sched_ns + $urandom_range(1600000, 400000);
                    15, 16:               sched_ns = sched_ns + $urandom;
                    17, 18:               sched_ns = sched_ns - $urandom_range(3000000);
                    default:              sched_ns = {$urandom, $urandom};
                endcase
                cmd.event_time = sched_ns;
            end
            send_cmd(cmd);
        end
    endtask

    initial begin
        ledger = new();
        for (int i = 0; i < KEY_POOL; i++) begin
            do task_keys[i] = {$urandom, $urandom}; while (task_keys[i] == 64'd0);
        end
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        run_directed();
        run_phase(MM_BOTH, MIN_DURATION_RST, 64'd0, 0, 6, 35, 110);
        run_phase(MM_BLOCKED, 64'd0, 64'd0, 84, 10, 35, 100);
        run_phase(MM_RUNQ, 64'd500000, 64'd2000000, 22, 6, 35, 110);
        run_phase(MM_RUNQ_ALT, MIN_DURATION_RST, '1, 0, 8, 35, 100);
        run_phase(MM_BOTH, 64'd0, 64'd1000000, 84, 90, 75, 120);
        run_phase(MM_BOTH, '1, 64'd0, 22, 6, 35, 100);
        run_phase(MM_BOTH, 64'd1, '1, 0, 90, 30, 110);
        wait_drained();
        if (ledger.mismatches == 0 && ledger.pending_results.size() == 0) begin
            $display("offcpu_interval_tracker test passed");
        end else begin
            $display("offcpu_interval_tracker test failed");
        end
        $finish;
    end
endmodule
